// ----- src/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

  localparam logic [7:0] PadChar    = 8'h3D;
  localparam logic [7:0] PlusChar   = 8'h2B;
  localparam logic [7:0] SlashChar  = 8'h2F;
  localparam logic [5:0] SliceMask  = 6'h3F;
  localparam logic [1:0] FillEmpty  = 2'd0;
  localparam logic [1:0] FillOne    = 2'd1;
  localparam logic [1:0] FillTwo    = 2'd2;
  localparam logic [1:0] LastSlice  = 2'd3;
  localparam int unsigned QueueDepth = 2;

  // One complete (or final partial) group on its way to the character stage.
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  npad;
    logic        eom;
  } group_t;

  // Maps a 6-bit value onto the standard base64 alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] code;
    begin
      if (idx < 6'd26) begin
        code = 8'h41 + {2'b00, idx};
      end else if (idx < 6'd52) begin
        code = 8'h61 + {2'b00, idx - 6'd26};
      end else if (idx < 6'd62) begin
        code = 8'h30 + {2'b00, idx - 6'd52};
      end else if (idx == 6'd62) begin
        code = PlusChar;
      end else begin
        code = SlashChar;
      end
      return code;
    end
  endfunction

endpackage

// ----- src/b64e_front.sv -----
// Byte collector: gathers bytes into 3-byte groups and hands each finished group on.
module b64e_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_message_i,
  input  logic                  q_full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output b64e_pkg::group_t      push_data_o
);

  logic [1:0]  fill_q, fill_d, fill_eff;
  logic [15:0] pend_q, pend_d;
  logic        accept;
  logic        close_group;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  // A fill count of three cannot arise; treat it as empty anyway.
  assign fill_eff   = (fill_q == 2'd3) ? b64e_pkg::FillEmpty : fill_q;
  assign close_group = end_of_message_i || (fill_eff == b64e_pkg::FillTwo);

  always_comb begin
    fill_d      = fill_q;
    pend_d      = pend_q;
    push_o      = 1'b0;
    push_data_o = '0;
    push_data_o.eom = end_of_message_i;
    case (fill_eff)
      b64e_pkg::FillEmpty: begin
        push_data_o.triple = {data_byte_i, 16'h0000};
        push_data_o.npad   = end_of_message_i ? 2'd2 : 2'd0;
      end
      b64e_pkg::FillOne: begin
        push_data_o.triple = {pend_q[7:0], data_byte_i, 8'h00};
        push_data_o.npad   = end_of_message_i ? 2'd1 : 2'd0;
      end
      default: begin
        push_data_o.triple = {pend_q, data_byte_i};
        push_data_o.npad   = 2'd0;
      end
    endcase
    if (accept) begin
      if (close_group) begin
        push_o = 1'b1;
        fill_d = b64e_pkg::FillEmpty;
        pend_d = '0;
      end else begin
        fill_d = fill_eff + 2'd1;
        pend_d = (fill_eff == b64e_pkg::FillEmpty) ? {8'h00, data_byte_i}
                                                   : {pend_q[7:0], data_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= b64e_pkg::FillEmpty;
      pend_q <= '0;
    end else begin
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ----- src/b64e_queue.sv -----
// Two-entry group queue between the byte collector and the character stage.
module b64e_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  b64e_pkg::group_t      push_data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output logic                  full_o,
  output b64e_pkg::group_t      head_o
);

  b64e_pkg::group_t entries_q [b64e_pkg::QueueDepth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'(b64e_pkg::QueueDepth));
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

// ----- src/b64e_back.sv -----
// Character stage: turns each queued group into four ASCII characters, one per cycle while the output is not stalled.
module b64e_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  b64e_pkg::group_t      q_head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            char_code_o,
  output logic                  final_char_o
);

  b64e_pkg::group_t cur_q;
  logic             busy_q, busy_d;
  logic [1:0]       pos_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       char_q;
  logic             final_q;
  logic             can_load;
  logic             emit;
  logic [5:0]       slice;
  logic             is_pad;
  logic [7:0]       next_char;

  assign can_load = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && can_load;
  assign pop_o    = q_valid_i && (!busy_q || (emit && pos_q == b64e_pkg::LastSlice));

  always_comb begin
    case (pos_q)
      2'd0:    slice = cur_q.triple[23:18];
      2'd1:    slice = cur_q.triple[17:12];
      2'd2:    slice = cur_q.triple[11:6];
      default: slice = cur_q.triple[5:0];
    endcase
    slice = slice & b64e_pkg::SliceMask;
    // Padding covers the trailing npad positions of the group.
    is_pad    = ({1'b0, pos_q} >= (3'd4 - {1'b0, cur_q.npad}));
    next_char = is_pad ? b64e_pkg::PadChar : b64e_pkg::b64_char(slice);
  end

  always_comb begin
    busy_d = busy_q;
    if (pop_o) begin
      busy_d = 1'b1;
    end else if (emit && pos_q == b64e_pkg::LastSlice) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_head_i;
    end
    if (emit) begin
      char_q  <= next_char;
      final_q <= cur_q.eom && (pos_q == b64e_pkg::LastSlice);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        pos_q <= 2'd0;
      end else if (emit) begin
        pos_q <= pos_q + 2'd1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_q;
  assign final_char_o = final_q;

endmodule

// ----- src/base64_stream_encoder.sv -----
// Top level of the base64 stream encoder: collector, group queue and character stage.
//
// Input channel: one raw byte per transaction (data_byte_i) with end_of_message_i
// on the last byte of a message. Output channel: one ASCII character per
// transaction (char_code_o), final_char_o set on the last character of a message.
// A transaction happens on a rising edge where valid is high and stall is low.
//
// Every third byte, or any byte with end_of_message_i, closes a group that goes
// into a two-entry queue; the character stage turns each group into four
// characters, '=' padding a short final group. The byte that closes a group passes
// through the queue entry, the group register and the character register to the output.
// Throughput: one byte per cycle on the input while the queue has room; the
// output runs at one character per cycle while not stalled; each group of three
// bytes yields four characters, so the single character register sets the byte rate.
// A stall on the output holds the character register; the queue then fills and
// in_stall_o rises, never before both queue entries are occupied.
// Reset clears the pending group, the queue and the output valid at once.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_code_o,
  output logic       final_char_o
);

  logic             q_push, q_pop, q_valid, q_full;
  b64e_pkg::group_t q_push_data, q_head;

  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .in_stall_o       (in_stall_o),
    .push_o           (q_push),
    .push_data_o      (q_push_data)
  );

  b64e_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .full_o      (q_full),
    .head_o      (q_head)
  );

  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_code_o  (char_code_o),
    .final_char_o (final_char_o)
  );

  // The collector never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("group pushed into a full queue");

  // The character stage only takes a group that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("group popped from an empty queue");

  // A padding character that is not the last one is always followed by padding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && char_code_o == b64e_pkg::PadChar && !final_char_o)
    |=> (!out_valid_o || char_code_o == b64e_pkg::PadChar))
    else $error("padding followed by a data character");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the base64 stream encoder with random idling and back-pressure.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePercent = 18;
  localparam int unsigned QuietStart  = 400;
  localparam int unsigned QuietEnd    = 700;
  localparam int unsigned HoldLength  = 60;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomBytes = 310;
  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } b64_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       end_of_message_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] char_code_o;
  logic       final_char_o;

  byte_item_t  pending_bytes_q[$];
  b64_char_t   expected_chars[$];
  logic [15:0] held_bytes = '0;
  logic [1:0]  held_count = b64e_pkg::FillEmpty;
  logic        byte_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned rx_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned error_count = 0;
  int unsigned chars_checked = 0;
  int unsigned message_count = 0;
  int unsigned byte_count = 0;

  base64_stream_encoder DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .char_code_o      (char_code_o),
    .final_char_o     (final_char_o)
  );

  always #6 clk_i = ~clk_i;

  // Updates the group state for one byte and queues the characters it completes.
  task automatic encode_byte(input logic [7:0] b, input logic eom);
    logic [23:0] group;
    logic [5:0]  slice;
    int          pads;
    b64_char_t   c;
    begin
      if (!eom && held_count != b64e_pkg::FillTwo) begin
        held_bytes = (held_count == b64e_pkg::FillEmpty) ? {8'h00, b}
                                                         : {held_bytes[7:0], b};
        held_count = held_count + 2'd1;
      end else begin
        case (held_count)
          b64e_pkg::FillEmpty: begin
            group = {b, 16'h0000};
            pads  = 2;
          end
          b64e_pkg::FillOne: begin
            group = {held_bytes[7:0], b, 8'h00};
            pads  = 1;
          end
          default: begin
            group = {held_bytes, b};
            pads  = 0;
          end
        endcase
        if (!eom) pads = 0;
        for (int i = 0; i < 4; i++) begin
          slice  = 6'((group >> (18 - 6 * i)) & 24'(b64e_pkg::SliceMask));
          c.code = (i >= 4 - pads) ? b64e_pkg::PadChar : Alphabet[511 - 8 * slice -: 8];
          c.fin  = eom && (i == 3);
          expected_chars.push_back(c);
        end
        held_bytes = '0;
        held_count = b64e_pkg::FillEmpty;
      end
    end
  endtask

  function automatic bit quiet_window();
    return cycle_count >= QuietStart && cycle_count < QuietEnd;
  endfunction

  task automatic add_message(input int len, input logic [7:0] fixed, input bit use_fixed);
    byte_item_t it;
    begin
      for (int i = 0; i < len; i++) begin
        it.data = use_fixed ? fixed : 8'($urandom);
        it.eom  = (i == len - 1);
        pending_bytes_q.push_back(it);
      end
      message_count++;
      byte_count += len;
    end
  endtask

  task automatic add_bytes(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                           input int len);
    byte_item_t it;
    logic [7:0] vals [3];
    begin
      vals = '{b0, b1, b2};
      for (int i = 0; i < len; i++) begin
        it.data = vals[i];
        it.eom  = (i == len - 1);
        pending_bytes_q.push_back(it);
      end
      message_count++;
      byte_count += len;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sender: a new byte is offered only once the previous transaction completed.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (pending_bytes_q.size() != 0 &&
          (quiet_window() || $urandom_range(99) >= IdlePercent)) begin
        in_valid_i       <= 1'b1;
        data_byte_i      <= pending_bytes_q[0].data;
        end_of_message_i <= pending_bytes_q[0].eom;
        pending_bytes_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus two long hold-offs that fill the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (rx_cycles == 150 || rx_cycles == 300) begin
        out_stall_i <= 1'b1;
        hold_left   <= HoldLength;
      end else begin
        out_stall_i <= !quiet_window() && ($urandom_range(99) < IdlePercent);
      end
    end
  end

  always @(posedge clk_i) begin
    byte_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) encode_byte(data_byte_i, end_of_message_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h (final %b)", char_code_o, final_char_o);
        error_count++;
      end else begin
        if (char_code_o !== expected_chars[0].code) begin
          $error("char_code: expected %h, actual %h", expected_chars[0].code, char_code_o);
          error_count++;
        end
        if (final_char_o !== expected_chars[0].fin) begin
          $error("final_char: expected %b, actual %b", expected_chars[0].fin, final_char_o);
          error_count++;
        end
        expected_chars.pop_front();
        chars_checked++;
      end
    end
  end

  initial begin
    int len;
    int random_bytes;
    // Short messages of every length class, extreme bytes and the '+' and '/' slices.
    add_message(1, 8'h00, 1'b1);
    add_message(1, 8'hFF, 1'b1);
    add_message(2, 8'hFF, 1'b1);
    add_message(3, 8'h00, 1'b1);
    add_bytes(8'hFB, 8'hEF, 8'hBE, 3);
    add_message(3, 8'hFF, 1'b1);
    add_bytes(8'h4D, 8'h61, 8'h6E, 2);
    add_message(4, 8'h00, 1'b0);
    add_message(5, 8'h00, 1'b0);
    random_bytes = 0;
    while (random_bytes < RandomBytes) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 11) : $urandom_range(10, 1);
      add_message(len, 8'h00, 1'b0);
      random_bytes += len;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      error_count++;
    end
    $display("Encoded %0d messages (%0d bytes), checked %0d characters,",
             message_count, byte_count, chars_checked);
    $display("with random idling on both sides and two long output hold-offs.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
